@@ rtl/core/fm_tone_generator_unit_macros.svh @@
// ---------------------------------------------------------------------------
// FM tone generator assertion macros
// Shared concurrent assertion forms for the checker of the voice ports.
// ---------------------------------------------------------------------------
`ifndef FM_TONE_GENERATOR_UNIT_MACROS_SVH
`define FM_TONE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define FMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also watches the reset itself
`define FMT_ASSERT_NEXT_RAW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator package
// Widths, command codes, queue word layout and elaboration-time table builders.
// ---------------------------------------------------------------------------
package fmt_pkg;

  localparam int SAMPLE_RATE    = 44100;
  localparam int SAMPLE_BITS    = 16;
  localparam int SINE_ADDR_BITS = 10;

  localparam int MAG_W      = SAMPLE_BITS - 1;
  localparam int FULL_SCALE = (1 << MAG_W) - 1;
  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 32;
  localparam int CMD_W      = 2;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int RATIO_W    = 16;
  localparam int DEPTH_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  // depth is Q0.16 of a cycle, phase is Q0.32
  localparam int OFFSET_FRAC = 16;
  // 127 = 2^7 - 1: amplitude scaling goes through the same divider
  localparam int AMP_SHIFT   = 7;
  localparam int AMP_ROUND   = 63;
  localparam int RATIO_ROUND = 128;
  localparam int RATIO_FRAC  = 8;

  localparam int PROD_W = DEPTH_W + MAG_W;
  localparam int DIV_W  = PROD_W + OFFSET_FRAC + 1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd307;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd585;

  // command codes on the input word
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CUT      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_CUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic [VEL_W-1:0]  velocity;
  } entry_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [DEPTH_W-1:0] depth;
  } cfg_t;

  typedef enum logic {
    DIV_OFFSET,
    DIV_AMP
  } div_mode_t;

  typedef struct packed {
    logic             start;
    div_mode_t        mode;
    logic [DIV_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // 2^(k/12) in Q16
  function automatic logic [16:0] semitone_q16(input logic [3:0] r);
    logic [16:0] v;
    case (r)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd69433;
      4'd2:    v = 17'd73562;
      4'd3:    v = 17'd77936;
      4'd4:    v = 17'd82570;
      4'd5:    v = 17'd87480;
      4'd6:    v = 17'd92682;
      4'd7:    v = 17'd98193;
      4'd8:    v = 17'd104032;
      4'd9:    v = 17'd110218;
      4'd10:   v = 17'd116772;
      4'd11:   v = 17'd123715;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // phase step of a MIDI note, Q0.32 of a cycle per sample
  function automatic logic [STEP_W-1:0] step_for_note(input logic [NOTE_W-1:0] note);
    logic [63:0] m;
    logic [63:0] oct;
    logic [63:0] num;
    m   = 64'(note) + 64'd3;
    oct = m / 64'd12;
    num = (64'(semitone_q16(4'(m % 64'd12))) * 64'd440) << (oct + 64'd10);
    return STEP_W'((num + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
  endfunction

  // quarter-wave sine magnitude, odd polynomial in Q30
  function automatic logic [MAG_W-1:0] sine_mag(input logic [63:0] off, input int abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    x   = (off * HALF_PI_Q30) >> (abits - 2);
    x2  = (x * x) >> 30;
    t   = ONE_Q30 - x2 / 64'd72;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (mag > 64'(FULL_SCALE)) begin
      mag = 64'(FULL_SCALE);
    end
    return MAG_W'(mag);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fmt_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator stream interfaces
// Valid/ready channels for command words in and sample words out.
// ---------------------------------------------------------------------------
interface fmt_in_if;
  import fmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;

  modport source (output valid, output command, output note, output velocity,
                  input ready);
  modport sink   (input valid, input command, input note, input velocity,
                  output ready);
endinterface

interface fmt_out_if;
  import fmt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          active;

  modport source (output valid, output sample, output active, input ready);
  modport sink   (input valid, input sample, input active, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fmt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator front end
// Takes command words, decodes the operation and looks up the note step.
// ---------------------------------------------------------------------------
module fmt_front (
  input  logic            clk,
  input  logic            rst_n,
  fmt_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output fmt_pkg::entry_t push_entry
);
  import fmt_pkg::*;

  localparam int NOTES = 1 << NOTE_W;

  logic [STEP_W-1:0] step_tab [0:NOTES-1];
  logic              hold_valid_r;
  logic              hold_valid_nxt;
  entry_t            hold_entry_r;
  op_t               op_dec;
  logic              in_fire;

  // note step table, built at elaboration
  for (genvar i = 0; i < NOTES; i++) begin : g_step
    assign step_tab[i] = step_for_note(NOTE_W'(i));
  end

  // command decode
  always_comb begin
    case (in_ch.command)
      CMD_TICK:     op_dec = OP_TICK;
      CMD_NOTE_ON:  op_dec = OP_NOTE_ON;
      CMD_NOTE_OFF: op_dec = OP_NOTE_OFF;
      CMD_CUT:      op_dec = OP_CUT;
      default:      op_dec = OP_NOTE_OFF;
    endcase
  end

  assign in_ch.ready = !hold_valid_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // hold stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_entry_r.op       <= op_dec;
      hold_entry_r.step     <= step_tab[in_ch.note];
      hold_entry_r.velocity <= in_ch.velocity;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_entry = hold_entry_r;

endmodule
`default_nettype wire

@@ rtl/core/fmt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator decode queue
// Short FIFO of decoded words between the front end and the voice engine.
// ---------------------------------------------------------------------------
module fmt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fmt_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fmt_pkg::entry_t pop_entry
);
  import fmt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  entry_t           slot_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fmt_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator constant divider
// Divides by 2^m - 1 through digit folding, one fold per cycle.
// ---------------------------------------------------------------------------
module fmt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fmt_pkg::div_req_t req,
  output fmt_pkg::div_rsp_t rsp
);
  import fmt_pkg::*;

  localparam logic [DIV_W-1:0] MASK_OFF = {{(DIV_W - MAG_W){1'b0}}, {MAG_W{1'b1}}};
  localparam logic [DIV_W-1:0] MASK_AMP = {{(DIV_W - AMP_SHIFT){1'b0}}, {AMP_SHIFT{1'b1}}};

  logic             busy_r;
  logic             done_r;
  div_mode_t        mode_r;
  logic [DIV_W-1:0] quot_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] hi;
  logic [DIV_W-1:0] lo;
  logic [DIV_W-1:0] mask;

  // N = q*(2^m-1) + r is kept; folding r = hi*2^m + lo gives q += hi, r = lo + hi
  always_comb begin
    mask = (mode_r == DIV_AMP) ? MASK_AMP : MASK_OFF;
    hi   = (mode_r == DIV_AMP) ? (rem_r >> AMP_SHIFT) : (rem_r >> MAG_W);
    lo   = rem_r & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // done pulses once, registered when a check finds no high digit left to fold
      done_r <= !req.start && busy_r && (hi == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (hi == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      quot_r <= '0;
      rem_r  <= req.num;
    end else if (busy_r) begin
      if (hi != '0) begin
        quot_r <= quot_r + hi;
        rem_r  <= lo + hi;
      end else if (rem_r == mask) begin
        // remainder equal to the divisor
        quot_r <= quot_r + 1'b1;
        rem_r  <= '0;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire

@@ rtl/core/fmt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator voice engine
// Holds the voice state, runs the two sine lookups and drives the sample word.
// ---------------------------------------------------------------------------
module fmt_back #(
  parameter int SINE_ADDR_BITS = fmt_pkg::SINE_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fmt_pkg::cfg_t     cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  fmt_pkg::entry_t   pop_entry,
  output fmt_pkg::div_req_t div_req,
  input  fmt_pkg::div_rsp_t div_rsp,
  fmt_out_if.source         out_ch
);
  import fmt_pkg::*;

  localparam int QBITS = SINE_ADDR_BITS - 2;
  localparam int QLEN  = 1 << QBITS;
  localparam int PROW  = STEP_W + RATIO_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTE,
    ST_IN_LOOK,
    ST_IN_MUL,
    ST_IN_DIV,
    ST_IN_WAIT,
    ST_OUT_LOOK,
    ST_OUT_MUL,
    ST_OUT_DIV,
    ST_OUT_WAIT,
    ST_EMIT
  } state_t;

  state_t                        state_r;
  logic [PHASE_W-1:0]            outer_phase_r;
  logic [PHASE_W-1:0]            inner_phase_r;
  logic [STEP_W-1:0]             outer_step_r;
  logic [STEP_W-1:0]             inner_step_r;
  logic [VEL_W-1:0]              amp_r;
  logic                          voice_on_r;
  logic [PHASE_W-1:0]            look_phase_r;
  logic [MAG_W-1:0]              mag_r;
  logic                          neg_r;
  logic [PROD_W-1:0]             prod_r;
  logic                          sign_r;
  logic signed [SAMPLE_BITS-1:0] res_sample_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_active_r;

  logic [MAG_W-1:0]          sine_tab [0:QLEN];
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [QBITS:0]            tab_off;
  logic [PROW-1:0]           ostep_prod;
  logic [PROW-1:0]           ostep_round;
  logic [PHASE_W-1:0]        off32;
  logic [MAG_W-1:0]          vmag;
  logic signed [SAMPLE_BITS-1:0] vsig;
  logic                      out_free;

  // quarter-wave sine table, built at elaboration
  for (genvar i = 0; i <= QLEN; i++) begin : g_sine
    assign sine_tab[i] = sine_mag(64'(i), SINE_ADDR_BITS);
  end

  // table address from the phase under lookup
  always_comb begin
    idx     = look_phase_r[PHASE_W-1 -: SINE_ADDR_BITS];
    quad    = idx[SINE_ADDR_BITS-1 -: 2];
    tab_off = quad[0] ? ((QBITS + 1)'(QLEN) - {1'b0, idx[QBITS-1:0]})
                      : {1'b0, idx[QBITS-1:0]};
  end

  always_ff @(posedge clk) begin
    mag_r <= sine_tab[tab_off];
    neg_r <= quad[1];
  end

  // outer step and phase offset
  always_comb begin
    ostep_prod  = PROW'(inner_step_r) * PROW'(cfg.ratio);
    ostep_round = ostep_prod + PROW'(RATIO_ROUND);
    off32       = sign_r ? (PHASE_W'(0) - div_rsp.quot[PHASE_W-1:0])
                         : div_rsp.quot[PHASE_W-1:0];
    vmag        = div_rsp.quot[MAG_W-1:0];
    vsig        = SAMPLE_BITS'({1'b0, vmag});
  end

  // divider requests
  always_comb begin
    div_req.start = (state_r == ST_IN_DIV) || (state_r == ST_OUT_DIV);
    div_req.mode  = (state_r == ST_OUT_DIV) ? DIV_AMP : DIV_OFFSET;
    if (state_r == ST_OUT_DIV) begin
      div_req.num = DIV_W'(prod_r) + DIV_W'(AMP_ROUND);
    end else begin
      div_req.num = DIV_W'({prod_r, {OFFSET_FRAC{1'b0}}}) + DIV_W'(FULL_SCALE / 2);
    end
  end

  assign pop_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;

  // voice sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      outer_phase_r <= '0;
      inner_phase_r <= '0;
      outer_step_r  <= '0;
      inner_step_r  <= '0;
      amp_r         <= '0;
      voice_on_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // word taken; in ST_EMIT a new word may replace it below
      if ((state_r != ST_EMIT) && out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          res_sample_r <= '0;
          if (pop_valid) begin
            case (pop_entry.op)
              OP_NOTE_ON: begin
                inner_step_r  <= pop_entry.step;
                amp_r         <= pop_entry.velocity;
                outer_phase_r <= '0;
                inner_phase_r <= '0;
                voice_on_r    <= 1'b1;
                state_r       <= ST_NOTE;
              end
              OP_CUT: begin
                voice_on_r <= 1'b0;
                state_r    <= ST_EMIT;
              end
              OP_TICK: begin
                look_phase_r <= inner_phase_r;
                state_r      <= voice_on_r ? ST_IN_LOOK : ST_EMIT;
              end
              default: begin
                state_r <= ST_EMIT;
              end
            endcase
          end
        end
        ST_NOTE: begin
          outer_step_r <= ostep_round[RATIO_FRAC +: STEP_W];
          state_r      <= ST_EMIT;
        end
        ST_IN_LOOK: begin
          state_r <= ST_IN_MUL;
        end
        ST_IN_MUL: begin
          prod_r  <= PROD_W'(cfg.depth) * PROD_W'(mag_r);
          sign_r  <= neg_r;
          state_r <= ST_IN_DIV;
        end
        ST_IN_DIV: begin
          state_r <= ST_IN_WAIT;
        end
        ST_IN_WAIT: begin
          if (div_rsp.done) begin
            look_phase_r <= outer_phase_r + off32;
            state_r      <= ST_OUT_LOOK;
          end
        end
        ST_OUT_LOOK: begin
          state_r <= ST_OUT_MUL;
        end
        ST_OUT_MUL: begin
          prod_r  <= PROD_W'(mag_r) * PROD_W'(amp_r);
          sign_r  <= neg_r;
          state_r <= ST_OUT_DIV;
        end
        ST_OUT_DIV: begin
          state_r <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (div_rsp.done) begin
            res_sample_r  <= sign_r ? -vsig : vsig;
            outer_phase_r <= outer_phase_r + outer_step_r;
            inner_phase_r <= inner_phase_r + inner_step_r;
            state_r       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_sample_r;
            out_active_r <= voice_on_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.active = out_active_r;

endmodule
`default_nettype wire

@@ rtl/core/fm_tone_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator
// Two-operator FM voice: decode front end, word queue, voice engine.
// ---------------------------------------------------------------------------
//  Channel   Dir   Handshake      Word
//  in_ch     in    valid/ready    command, note, velocity
//  out_ch    out   valid/ready    sample, active
//  cfg_*     in    write enable   frequency_ratio (0), modulation_depth (1)
//
//  Sequence: cut, note off and a tick of a silent voice go from idle straight
//  to emit in the voice engine, note on first sets the outer step, a tick of a
//  sounding voice runs two sine table lookups, each followed by a pass through
//  the shared divide-by-(2^m-1) unit, which folds one digit per cycle.
//  Reset: synchronous, all voice state and handshakes clear.
//  Stalls: the four-word queue keeps command words flowing while a sample
//  word waits on out_ch.
// ---------------------------------------------------------------------------
module fm_tone_generator_unit #(
  parameter int SINE_ADDR_BITS = fmt_pkg::SINE_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fmt_in_if.sink                        in_ch,
  fmt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [fmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmt_pkg::CFG_W-1:0]     cfg_data
);
  import fmt_pkg::*;

  cfg_t     cfg_r;
  logic     push_valid;
  logic     push_ready;
  entry_t   push_entry;
  logic     pop_valid;
  logic     pop_ready;
  entry_t   pop_entry;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio <= RATIO_RESET;
      cfg_r.depth <= DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_RATIO: cfg_r.ratio <= RATIO_W'(cfg_data);
        REG_MOD_DEPTH:  cfg_r.depth <= DEPTH_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  fmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  fmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  fmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fmt_back #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/fmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FM tone generator port checker
// Watches the handshakes and sample words at the top-level ports.
// ---------------------------------------------------------------------------
`include "fm_tone_generator_unit_macros.svh"

module fmt_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [fmt_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic                                 out_active
);
  import fmt_pkg::*;

  // a stalled sample word stays up
  `FMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out word dropped while stalled")

  // and keeps its contents
  `FMT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample) && $stable(out_active), "out word changed while stalled")

  // a silent voice never shows a nonzero sample
  `FMT_ASSERT_SAME(a_silent_zero, clk, rst_n, out_valid && !out_active, out_sample == '0, "nonzero sample from inactive voice")

  // reset leaves no word pending and the front end open
  `FMT_ASSERT_NEXT_RAW(a_reset_out, clk, !rst_n, !out_valid, "out word valid after reset")
  `FMT_ASSERT_NEXT_RAW(a_reset_in, clk, !rst_n, in_ready, "front end closed after reset")

endmodule

bind fm_tone_generator_unit fmt_checker u_fmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample),
  .out_active (out_ch.active)
);
`default_nettype wire
